@@ rtl/core/mhe_pkg.sv @@
// Shared types, widths and controller codes for the modular Horner evaluator.
package mhe_pkg;

  localparam int unsigned WORD_WIDTH = 32;
  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned DIV_W      = 2 * WORD_WIDTH;
  localparam int unsigned CNT_W      = $clog2(DIV_W + 1);

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [DIV_W-1:0]      dword_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  localparam cnt_t PT_STEPS   = cnt_t'(WORD_WIDTH);
  localparam cnt_t PROD_STEPS = cnt_t'(DIV_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_PT,
    S_MUL,
    S_RLD,
    S_RED,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic zero_clear;
    logic red_load_pt;
    logic red_load_prod;
    logic red_step;
    logic pt_write;
    logic mul;
    logic acc_write;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mzero;
    logic first;
    logic last;
    logic red_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/core/mhe_modred.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle while step_i is high, MSB first.
module mhe_modred (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  logic           step_i,
  input  mhe_pkg::dword_t dividend_i,
  input  mhe_pkg::cnt_t  steps_i,
  input  mhe_pkg::word_t modulus_i,
  output mhe_pkg::word_t rem_o,
  output logic           done_o
);

  mhe_pkg::dword_t            div_q;
  mhe_pkg::word_t             rem_q;
  mhe_pkg::cnt_t              cnt_q;
  logic [mhe_pkg::WORD_WIDTH:0] trial;
  logic                       active;

  assign trial  = {rem_q, div_q[mhe_pkg::DIV_W-1]};
  assign active = step_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= steps_i;
    end else if (active) begin
      cnt_q <= cnt_q - mhe_pkg::cnt_t'(1);
    end
  end

  // The partial remainder stays below the modulus, so one subtract per bit is enough.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      div_q <= dividend_i;
      rem_q <= '0;
    end else if (active) begin
      div_q <= div_q << 1;
      if (trial >= {1'b0, modulus_i}) begin
        rem_q <= mhe_pkg::word_t'(trial - {1'b0, modulus_i});
      end else begin
        rem_q <= mhe_pkg::word_t'(trial);
      end
    end
  end

  assign rem_o  = rem_q;
  assign done_o = (cnt_q == '0);

  a_cnt_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active && !load_i) |=> (cnt_q == $past(cnt_q) - mhe_pkg::cnt_t'(1)))
    else $error("remainder step count did not advance by one");

endmodule

@@ rtl/core/mhe_dp.sv @@
// Datapath: modulus, accumulator, point, product and output registers.
module mhe_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mhe_pkg::FIELD_W-1:0] cfg_wdata_i,
  input  logic [mhe_pkg::FIELD_W-1:0] coefficient_i,
  input  logic [mhe_pkg::FIELD_W-1:0] eval_point_i,
  input  logic                       first_item_i,
  input  logic                       last_item_i,
  input  logic                       out_ready_i,
  input  mhe_pkg::ctrl_cmd_t         cmd_i,
  output mhe_pkg::dp_status_t        status_o,
  output logic                       out_valid_o,
  output logic [mhe_pkg::FIELD_W-1:0] value_o,
  output logic                       modulus_zero_o
);

  mhe_pkg::word_t  modulus_q;
  mhe_pkg::word_t  acc_q;
  mhe_pkg::word_t  point_q;
  mhe_pkg::word_t  coef_q;
  mhe_pkg::word_t  pt_in_q;
  mhe_pkg::dword_t prod_q;
  logic            first_q;
  logic            last_q;
  logic            mzero_q;
  logic            out_valid_q;
  mhe_pkg::word_t  out_value_q;
  logic            out_mzero_q;

  mhe_pkg::dword_t prod_full;
  mhe_pkg::dword_t red_dividend;
  mhe_pkg::cnt_t   red_steps;
  mhe_pkg::word_t  red_rem;
  logic            red_done;

  assign prod_full = mhe_pkg::dword_t'(acc_q) * mhe_pkg::dword_t'(point_q);

  always_comb begin
    if (cmd_i.red_load_pt) begin
      red_dividend = {pt_in_q, {mhe_pkg::WORD_WIDTH{1'b0}}};
      red_steps    = mhe_pkg::PT_STEPS;
    end else begin
      red_dividend = prod_q + mhe_pkg::dword_t'(coef_q);
      red_steps    = mhe_pkg::PROD_STEPS;
    end
  end

  mhe_modred u_modred (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (cmd_i.red_load_pt || cmd_i.red_load_prod),
    .step_i     (cmd_i.red_step),
    .dividend_i (red_dividend),
    .steps_i    (red_steps),
    .modulus_i  (modulus_q),
    .rem_o      (red_rem),
    .done_o     (red_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= '0;
    end else if (cfg_we_i) begin
      modulus_q <= mhe_pkg::word_t'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      point_q <= '0;
    end else if (cmd_i.zero_clear) begin
      acc_q <= '0;
      if (first_q) begin
        point_q <= '0;
      end
    end else if (cmd_i.pt_write) begin
      point_q <= red_rem;
      acc_q   <= '0;
    end else if (cmd_i.acc_write) begin
      acc_q <= red_rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b0;
      last_q  <= 1'b0;
      mzero_q <= 1'b0;
    end else if (cmd_i.load) begin
      first_q <= first_item_i;
      last_q  <= last_item_i;
      mzero_q <= (modulus_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      coef_q  <= mhe_pkg::word_t'(coefficient_i);
      pt_in_q <= mhe_pkg::word_t'(eval_point_i);
    end
    if (cmd_i.mul) begin
      prod_q <= prod_full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // On a zero modulus the accumulator was already cleared, so it reads as zero here.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_value_q <= acc_q;
      out_mzero_q <= mzero_q;
    end
  end

  assign status_o.mzero    = mzero_q;
  assign status_o.first    = first_q;
  assign status_o.last     = last_q;
  assign status_o.red_done = red_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign value_o        = mhe_pkg::FIELD_W'(out_value_q);
  assign modulus_zero_o = out_mzero_q;

endmodule

@@ rtl/core/mhe_ctrl.sv @@
// Controller state machine that sequences one Horner step at a time.
module mhe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mhe_pkg::dp_status_t status_i,
  output mhe_pkg::ctrl_cmd_t  cmd_o
);

  mhe_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mhe_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mhe_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mhe_pkg::S_CHK;
        end
      end
      mhe_pkg::S_CHK: begin
        if (status_i.mzero) begin
          cmd_o.zero_clear = 1'b1;
          state_d = status_i.last ? mhe_pkg::S_OUT : mhe_pkg::S_IDLE;
        end else if (status_i.first) begin
          cmd_o.red_load_pt = 1'b1;
          state_d           = mhe_pkg::S_PT;
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = mhe_pkg::S_RLD;
        end
      end
      mhe_pkg::S_PT: begin
        if (status_i.red_done) begin
          cmd_o.pt_write = 1'b1;
          state_d        = mhe_pkg::S_MUL;
        end else begin
          cmd_o.red_step = 1'b1;
        end
      end
      mhe_pkg::S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = mhe_pkg::S_RLD;
      end
      mhe_pkg::S_RLD: begin
        cmd_o.red_load_prod = 1'b1;
        state_d             = mhe_pkg::S_RED;
      end
      mhe_pkg::S_RED: begin
        if (status_i.red_done) begin
          cmd_o.acc_write = 1'b1;
          state_d = status_i.last ? mhe_pkg::S_OUT : mhe_pkg::S_IDLE;
        end else begin
          cmd_o.red_step = 1'b1;
        end
      end
      mhe_pkg::S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = mhe_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mhe_pkg::S_IDLE;
      end
    endcase
  end

  a_accept_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == mhe_pkg::S_CHK))
    else $error("accepted beat was not followed by the check state");

  a_out_leave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mhe_pkg::S_OUT && status_i.out_free) |=> (state_q == mhe_pkg::S_IDLE))
    else $error("result was not handed to the output register when it was free");

  a_no_step_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.red_step && (cmd_o.red_load_pt || cmd_o.red_load_prod)))
    else $error("remainder unit stepped and loaded in the same cycle");

endmodule

@@ rtl/core/modular_polynomial_horner_eval_core.sv @@
// Top level of the modular Horner polynomial evaluator.
// Evaluates a polynomial mod the modulus register, one coefficient per input beat, highest
// degree first; first_item_i latches the point (reduced mod the modulus) and clears the
// accumulator, and last_item_i produces one result beat. Ready stays low from a beat's
// acceptance until the block is through with it. The work is set by the bit-serial remainder
// unit that reduces the 64-bit product-plus-coefficient one bit per cycle. A first beat also
// reduces the point before that, and a last beat then loads the output register, waiting
// while that register still holds an unread result. With a zero modulus a beat skips the
// reduction and a last beat yields value 0 with modulus_zero_o set. The result waits in an
// output register, so a new beat is taken while it is pending. Write the modulus only while
// the block is idle.
module modular_polynomial_horner_eval_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mhe_pkg::FIELD_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [mhe_pkg::FIELD_W-1:0] coefficient_i,
  input  logic [mhe_pkg::FIELD_W-1:0] eval_point_i,
  input  logic                        first_item_i,
  input  logic                        last_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mhe_pkg::FIELD_W-1:0] value_o,
  output logic                        modulus_zero_o
);

  mhe_pkg::ctrl_cmd_t  cmd;
  mhe_pkg::dp_status_t status;

  mhe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mhe_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .coefficient_i  (coefficient_i),
    .eval_point_i   (eval_point_i),
    .first_item_i   (first_item_i),
    .last_item_i    (last_item_i),
    .out_ready_i    (out_ready_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .value_o        (value_o),
    .modulus_zero_o (modulus_zero_o)
  );

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the modular Horner polynomial evaluator core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef mhe_pkg::word_t word_t;

  typedef struct {
    word_t coef;
    word_t point;
    bit    first;
    bit    last;
  } coef_beat_t;

  typedef struct {
    word_t value;
    bit    mzero;
  } horner_result_t;

  localparam int unsigned IDLE_PCT      = 29;
  localparam int unsigned DRAIN_CYCLES  = 150;
  localparam int unsigned HOLD_CYCLES   = 800;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned CALM_START    = 30000;
  localparam int unsigned CALM_END      = 45000;
  localparam int unsigned PHASE_BEATS   = 112;

  logic  clk         = 1'b0;
  logic  rst_n       = 1'b0;
  logic  cfg_we      = 1'b0;
  word_t cfg_wdata   = '0;
  logic  in_valid    = 1'b0;
  logic  in_ready;
  word_t coefficient = '0;
  word_t eval_point  = '0;
  logic  first_item  = 1'b0;
  logic  last_item   = 1'b0;
  logic  out_valid;
  logic  out_ready   = 1'b0;
  word_t value;
  logic  modulus_zero;

  // Beats waiting to be driven and results waiting to come out.
  coef_beat_t     beat_queue[$];
  horner_result_t horner_results[$];

  // Predictor state.
  word_t cur_modulus = '0;
  word_t horner_acc  = '0;
  word_t held_point  = '0;

  int unsigned cycle_cnt    = 0;
  int unsigned stall_cycles = 0;
  int unsigned hold_left    = 0;
  int unsigned results_seen = 0;
  int unsigned errors       = 0;

  always #5 clk = ~clk;

  modular_polynomial_horner_eval_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .coefficient_i  (coefficient),
    .eval_point_i   (eval_point),
    .first_item_i   (first_item),
    .last_item_i    (last_item),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .value_o        (value),
    .modulus_zero_o (modulus_zero)
  );

  function automatic bit calm_window();
    return (cycle_cnt >= CALM_START) && (cycle_cnt < CALM_END);
  endfunction

  // One Horner step on an accepted beat; a last beat queues the expected result.
  function automatic void advance_horner(word_t coef, word_t pt, bit first, bit last);
    bit [63:0]      prod;
    bit [63:0]      rem;
    bit             mzero;
    horner_result_t res;
    mzero = (cur_modulus == '0);
    if (first) begin
      horner_acc = '0;
      held_point = mzero ? '0 : pt % cur_modulus;
    end
    if (mzero) begin
      horner_acc = '0;
    end else begin
      prod = 64'(horner_acc) * 64'(held_point);
      rem  = prod % 64'(cur_modulus);
      rem  = (rem + 64'(coef)) % 64'(cur_modulus);
      horner_acc = rem[31:0];
    end
    if (last) begin
      res.value = mzero ? '0 : horner_acc;
      res.mzero = mzero;
      horner_results.push_back(res);
    end
  endfunction

  function automatic word_t pick_word(word_t m);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return m - 1;
      3:       return m;
      4:       return m + 1;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_beat(word_t coef, word_t pt, bit first, bit last);
    coef_beat_t b;
    b.coef  = coef;
    b.point = pt;
    b.first = first;
    b.last  = last;
    beat_queue.push_back(b);
  endtask

  // Mostly complete polynomials with random content, plus stray and truncated beats.
  task automatic queue_random_polys(int unsigned n);
    int unsigned count;
    int unsigned len;
    bit          truncate;
    count = 0;
    while (count < n) begin
      if ($urandom_range(0, 99) < 15) begin
        push_beat(pick_word(cur_modulus), pick_word(cur_modulus),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        count++;
      end else begin
        len      = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 24);
        truncate = ($urandom_range(0, 99) < 5);
        for (int unsigned k = 0; k < len; k++) begin
          push_beat(pick_word(cur_modulus), (k == 0) ? pick_word(cur_modulus) : $urandom,
                    k == 0, (k == len - 1) && !truncate);
        end
        count += len;
      end
    end
  endtask

  task automatic load_modulus(word_t m);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    cur_modulus = m;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every beat is in and every result is out, then lets the core settle.
  task automatic drain();
    @(negedge clk);
    while (beat_queue.size() != 0 || in_valid || horner_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_random_phase(word_t m);
    load_modulus(m);
    queue_random_polys(PHASE_BEATS);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Zero modulus straight out of reset, including a beat before any first beat.
    push_beat(32'd5, 32'd9, 1'b0, 1'b1);
    push_beat('1, '1, 1'b1, 1'b1);
    push_beat(32'd1, 32'd2, 1'b1, 1'b0);
    push_beat(32'd3, '0, 1'b0, 1'b1);
    drain();

    // Largest modulus: coefficients below and at it, a point equal to it.
    load_modulus('1);
    push_beat(32'd7, '0, 1'b0, 1'b0);
    push_beat('1, '0, 1'b0, 1'b1);
    push_beat(32'hFFFF_FFFE, '1, 1'b1, 1'b1);
    push_beat(32'hFFFF_FFFE, 32'hFFFF_FFFE, 1'b1, 1'b0);
    push_beat(32'hFFFF_FFFE, '0, 1'b0, 1'b0);
    push_beat(32'hFFFF_FFFE, '0, 1'b0, 1'b1);
    push_beat('0, '0, 1'b1, 1'b1);
    push_beat(32'd1, 32'hFFFF_FFF0, 1'b1, 1'b0);
    drain();

    // New modulus while a polynomial is open; the held point keeps its old reduction.
    load_modulus(32'd1000003);
    push_beat(32'd2, '0, 1'b0, 1'b0);
    push_beat('1, '0, 1'b0, 1'b1);
    push_beat('0, '1, 1'b1, 1'b0);
    push_beat(32'd1, '0, 1'b0, 1'b1);
    drain();

    load_modulus(32'd1);
    push_beat('1, '1, 1'b1, 1'b0);
    push_beat('1, '0, 1'b0, 1'b1);
    drain();

    load_modulus(32'd2);
    push_beat(32'd1, 32'd3, 1'b1, 1'b0);
    push_beat(32'd1, '0, 1'b0, 1'b0);
    push_beat(32'd1, '0, 1'b0, 1'b1);
    drain();

    run_random_phase(32'h8000_0000);
    run_random_phase('0);
    run_random_phase($urandom);
    run_random_phase('1);
    run_random_phase(32'd3);
    run_random_phase($urandom_range(2, 1000));
    run_random_phase($urandom);
    run_random_phase(32'hFFFF_FFFB);
    run_random_phase(32'd1);
    run_random_phase($urandom | 32'h8000_0000);
    run_random_phase(32'h0001_0000);
    run_random_phase($urandom);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Sender: offers the next queued beat, idling at random outside the calm window.
  always @(posedge clk) begin : drive_beats
    bit         accepted;
    bit         offer;
    coef_beat_t b;
    if (rst_n) begin
      accepted = in_valid && in_ready;
      if (accepted) begin
        advance_horner(coefficient, eval_point, first_item, last_item);
      end
      if (!in_valid || accepted) begin
        offer = (beat_queue.size() != 0) &&
                (calm_window() || $urandom_range(0, 99) >= IDLE_PCT);
        if (offer) begin
          b = beat_queue.pop_front();
          coefficient <= b.coef;
          eval_point  <= b.point;
          first_item  <= b.first;
          last_item   <= b.last;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat and sometimes holds off long enough to back up the core.
  always @(posedge clk) begin : check_results
    horner_result_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (horner_results.size() == 0) begin
          $error("result beat with no result expected: value %h, modulus_zero %b",
                 value, modulus_zero);
          errors++;
        end else begin
          exp_r = horner_results.pop_front();
          if (value !== exp_r.value) begin
            $error("value: expected %h, actual %h", exp_r.value, value);
            errors++;
          end
          if (modulus_zero !== exp_r.mzero) begin
            $error("modulus_zero: expected %b, actual %b", exp_r.mzero, modulus_zero);
            errors++;
          end
          results_seen++;
          if (results_seen == 60 || results_seen == 500) begin
            hold_left = HOLD_CYCLES;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm_window() || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule
